### src/nfpm_pkg.sv
package nfpm_pkg;

   // Default sizes of the point table and of one coordinate.
   localparam int MAX_POINTS_DEF  = 64;
   localparam int COORD_WIDTH_DEF = 16;

   // Fixed field widths of the request and response items.
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 6;
   localparam int DIST_W   = 33;

   // Request commands.
   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_REPORT = 2'd3
   } cmd_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      STS_MATCHED = 3'd0,
      STS_NO_FREE = 3'd1,
      STS_UNUSED  = 3'd2,
      STS_NONE    = 3'd3,
      STS_FULL    = 3'd4
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_Q_SEEK,
      ST_Q_X,
      ST_Q_Y,
      ST_Q_CMP,
      ST_REPORT,
      ST_SINGLE
   } state_type;

endpackage

### src/nfpm_if.sv
// Request channel: command and position.
interface nfpm_req_if #(
   parameter int COORD_WIDTH = nfpm_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic [nfpm_pkg::CMD_W-1:0]    cmd;
   logic signed [COORD_WIDTH-1:0] pos_x;
   logic signed [COORD_WIDTH-1:0] pos_y;

   modport source (output valid, output cmd, output pos_x, output pos_y, input ready);
   modport sink (input valid, input cmd, input pos_x, input pos_y, output ready);
endinterface

// Response channel: status, index, distance and last flag.
interface nfpm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [nfpm_pkg::STATUS_W-1:0] status;
   logic [nfpm_pkg::INDEX_W-1:0]  point_index;
   logic [nfpm_pkg::DIST_W-1:0]   dist_sq;
   logic                          last;

   modport source (output valid, output status, output point_index, output dist_sq,
                   output last, input ready);
   modport sink (input valid, input status, input point_index, input dist_sq,
                 input last, output ready);
endinterface

### src/nearest_free_point_matcher.sv
// Nearest free point matcher. The block holds a table of up to MAX_POINTS
// points in a RAM, each with a used flag in flip-flops. Clear empties the
// table and add appends a point; neither gives a result item, except an
// add to a full table, which answers with status full. A query walks the
// table under a small sequencer that drives one shared squarer: a used
// entry is skipped, an unused one goes through RAM read, x square, y
// square, and add and compare. A query holds the request side off from
// when it is taken until its answer is loaded, and longer while the
// response output stalls. The nearest unused point is marked used and its
// index and squared distance returned, the lowest index winning ties. A
// report steps through the table one entry a cycle while the response
// output is free, and emits one item per unused entry, the final one with
// last set, or a single status none item. Every response sits in an output
// register; when it is not taken, the sequencer waits. Requests are taken
// only while the sequencer is idle.
module nearest_free_point_matcher #(
   parameter int MAX_POINTS  = nfpm_pkg::MAX_POINTS_DEF,
   parameter int COORD_WIDTH = nfpm_pkg::COORD_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   nfpm_req_if.sink   req_chan,
   nfpm_rsp_if.source rsp_chan
);

   localparam int IW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int SQ_W   = 2 * COORD_WIDTH;
   localparam int SUM_W  = 2 * COORD_WIDTH + 1;
   localparam int DIST_W = nfpm_pkg::DIST_W;
   localparam int INDEX_W = nfpm_pkg::INDEX_W;

   nfpm_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [MAX_POINTS-1:0] used_ff, used_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 found_ff, found_in;
   logic [IW-1:0]        best_idx_ff, best_idx_in;
   logic [SUM_W-1:0]     best_dist_ff, best_dist_in;
   logic signed [COORD_WIDTH-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [SQ_W-1:0]      sq_a_ff, sq_a_in, sq_b_ff, sq_b_in;
   nfpm_pkg::status_type pend_ff, pend_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   nfpm_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [DIST_W-1:0]    rsp_dist_ff, rsp_dist_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [2*COORD_WIDTH-1:0] ram_wr_data;
   logic [2*COORD_WIDTH-1:0] ram_rd_data;

   logic signed [COORD_WIDTH-1:0] opnd_a, opnd_b;
   logic signed [COORD_WIDTH:0]   diff;
   logic [COORD_WIDTH:0]          diff_neg;
   logic [COORD_WIDTH-1:0]        mag;
   logic [SQ_W-1:0]               sq_prod;
   logic [SUM_W-1:0]              sum;

   logic                  accept;
   logic                  out_free;
   logic                  table_full;
   logic                  scan_done;
   logic                  cur_used;
   logic [MAX_POINTS-1:0] free_vec;
   logic [MAX_POINTS-1:0] above_vec;
   logic                  more_above;
   logic [IW+INDEX_W-1:0] idx_ext;
   logic [IW+INDEX_W-1:0] best_ext;
   logic [SUM_W+DIST_W-1:0] dist_ext;

   // Point storage: x in the upper half of the word, y in the lower half.
   nfpm_ram #(
      .WIDTH (2 * COORD_WIDTH),
      .DEPTH (MAX_POINTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign ram_wr_data = {req_chan.pos_x, req_chan.pos_y};

   // Shared squarer: absolute difference of one coordinate, then its square.
   always_comb begin
      if (state_ff == nfpm_pkg::ST_Q_Y) begin
         opnd_a = ram_rd_data[COORD_WIDTH-1:0];
         opnd_b = qy_ff;
      end else begin
         opnd_a = ram_rd_data[2*COORD_WIDTH-1:COORD_WIDTH];
         opnd_b = qx_ff;
      end
   end

   assign diff     = $signed({opnd_a[COORD_WIDTH-1], opnd_a})
                   - $signed({opnd_b[COORD_WIDTH-1], opnd_b});
   assign diff_neg = -diff;
   assign mag      = diff[COORD_WIDTH] ? diff_neg[COORD_WIDTH-1:0] : diff[COORD_WIDTH-1:0];
   assign sq_prod  = {{COORD_WIDTH{1'b0}}, mag} * {{COORD_WIDTH{1'b0}}, mag};
   assign sum      = {1'b0, sq_a_ff} + {1'b0, sq_b_ff};

   // Handshake and scan status.
   assign accept     = req_chan.valid && req_chan.ready;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign table_full = (count_ff == CNT_W'(MAX_POINTS));
   assign scan_done  = (idx_ff == count_ff);
   assign cur_used   = used_ff[idx_ff[IW-1:0]];
   assign idx_ext    = {{INDEX_W{1'b0}}, idx_ff[IW-1:0]};
   assign best_ext   = {{INDEX_W{1'b0}}, best_idx_ff};
   assign dist_ext   = {{DIST_W{1'b0}}, best_dist_ff};

   // Free entries after the current scan position decide the last flag.
   always_comb begin
      for (int k = 0; k < MAX_POINTS; k++) begin
         free_vec[k]  = !used_ff[k] && (CNT_W'(k) < count_ff);
         above_vec[k] = (CNT_W'(k) > idx_ff);
      end
   end

   assign more_above = |(free_vec & above_vec);

   // Sequencer: next state, table updates and response loading.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_dist_in  = best_dist_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      sq_a_in       = sq_a_ff;
      sq_b_in       = sq_b_ff;
      pend_in       = pend_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         nfpm_pkg::ST_IDLE: begin
            if (accept) begin
               idx_in   = '0;
               found_in = 1'b0;
               qx_in    = req_chan.pos_x;
               qy_in    = req_chan.pos_y;
               unique case (nfpm_pkg::cmd_type'(req_chan.cmd))
                  nfpm_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     used_in  = '0;
                  end
                  nfpm_pkg::CMD_ADD: begin
                     if (table_full) begin
                        pend_in  = nfpm_pkg::STS_FULL;
                        state_in = nfpm_pkg::ST_SINGLE;
                     end else begin
                        ram_wr_en                  = 1'b1;
                        used_in[count_ff[IW-1:0]]  = 1'b0;
                        count_in                   = count_ff + CNT_W'(1);
                     end
                  end
                  nfpm_pkg::CMD_QUERY: begin
                     state_in = nfpm_pkg::ST_Q_SEEK;
                  end
                  nfpm_pkg::CMD_REPORT: begin
                     state_in = nfpm_pkg::ST_REPORT;
                  end
               endcase
            end
         end

         // Skip used entries; read the next unused one, or end the scan at the table's end.
         nfpm_pkg::ST_Q_SEEK: begin
            priority if (scan_done) begin
               pend_in  = found_ff ? nfpm_pkg::STS_MATCHED : nfpm_pkg::STS_NO_FREE;
               state_in = nfpm_pkg::ST_SINGLE;
            end else if (cur_used) begin
               idx_in = idx_ff + CNT_W'(1);
            end else begin
               ram_rd_en = 1'b1;
               state_in  = nfpm_pkg::ST_Q_X;
            end
         end

         nfpm_pkg::ST_Q_X: begin
            sq_a_in  = sq_prod;
            state_in = nfpm_pkg::ST_Q_Y;
         end

         nfpm_pkg::ST_Q_Y: begin
            sq_b_in  = sq_prod;
            state_in = nfpm_pkg::ST_Q_CMP;
         end

         // Keep the first strictly smaller distance.
         nfpm_pkg::ST_Q_CMP: begin
            if (!found_ff || (sum < best_dist_ff)) begin
               found_in     = 1'b1;
               best_idx_in  = idx_ff[IW-1:0];
               best_dist_in = sum;
            end
            idx_in   = idx_ff + CNT_W'(1);
            state_in = nfpm_pkg::ST_Q_SEEK;
         end

         // Emit one item per unused entry, waiting on a busy output.
         nfpm_pkg::ST_REPORT: begin
            priority if (scan_done) begin
               if (found_ff) begin
                  state_in = nfpm_pkg::ST_IDLE;
               end else begin
                  pend_in  = nfpm_pkg::STS_NONE;
                  state_in = nfpm_pkg::ST_SINGLE;
               end
            end else if (cur_used) begin
               idx_in = idx_ff + CNT_W'(1);
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = nfpm_pkg::STS_UNUSED;
               rsp_index_in  = idx_ext[INDEX_W-1:0];
               rsp_dist_in   = '0;
               rsp_last_in   = !more_above;
               found_in      = 1'b1;
               idx_in        = idx_ff + CNT_W'(1);
            end
         end

         // Single closing item; a match marks its point used.
         nfpm_pkg::ST_SINGLE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_ff;
               rsp_last_in   = 1'b1;
               if (pend_ff == nfpm_pkg::STS_MATCHED) begin
                  rsp_index_in         = best_ext[INDEX_W-1:0];
                  rsp_dist_in          = dist_ext[DIST_W-1:0];
                  used_in[best_idx_ff] = 1'b1;
               end else begin
                  rsp_index_in = '0;
                  rsp_dist_in  = '0;
               end
               state_in = nfpm_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = nfpm_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nfpm_pkg::ST_IDLE;
         count_ff     <= '0;
         used_ff      <= '0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      best_idx_ff   <= best_idx_in;
      best_dist_ff  <= best_dist_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      sq_a_ff       <= sq_a_in;
      sq_b_ff       <= sq_b_in;
      pend_ff       <= pend_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Channel outputs.
   assign req_chan.ready       = (state_ff == nfpm_pkg::ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.point_index = rsp_index_ff;
   assign rsp_chan.dist_sq     = rsp_dist_ff;
   assign rsp_chan.last        = rsp_last_ff;

`ifndef SYNTHESIS
   // The fill count never passes the table size.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count exceeds table size");

   // A scan never runs past the filled part of the table.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != nfpm_pkg::ST_IDLE) |-> (idx_ff <= count_ff))
      else $error("scan index beyond point count");

   // An add to a table with room grows the count by one.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.cmd == nfpm_pkg::CMD_ADD) && !table_full)
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("add did not grow the point count");
`endif

endmodule

### src/nfpm_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module nfpm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read; the read data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/nearest_free_point_matcher_test.sv
module nearest_free_point_matcher_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH    = nfpm_pkg::MAX_POINTS_DEF;
   localparam int COORD_W        = nfpm_pkg::COORD_WIDTH_DEF;
   localparam int INDEX_W        = nfpm_pkg::INDEX_W;
   localparam int DIST_W         = nfpm_pkg::DIST_W;
   localparam int CMD_W          = nfpm_pkg::CMD_W;
   localparam int RANDOM_ITEMS   = 240;
   // A query over a full table of unused points is the slowest item.
   localparam int SETTLE_CYCLES  = 4 * TABLE_DEPTH + 40;
   localparam int WATCHDOG_LIMIT = 4000;

   // One expected response item.
   typedef struct packed {
      nfpm_pkg::status_type status;
      logic [INDEX_W-1:0]   point_index;
      logic [DIST_W-1:0]    dist_sq;
      logic                 last;
   } answer_type;

   logic clock;
   logic reset;

   nfpm_req_if #(.COORD_WIDTH(COORD_W)) req_bus ();
   nfpm_rsp_if rsp_bus ();

   nearest_free_point_matcher dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Shadow copy of the point table.
   logic signed [COORD_W-1:0] shadow_x [TABLE_DEPTH];
   logic signed [COORD_W-1:0] shadow_y [TABLE_DEPTH];
   bit                        shadow_used [TABLE_DEPTH];
   int                        shadow_count;

   answer_type pending_answers[$];

   bit calm;
   int errors;
   int quiet_cycles;
   int items_sent;
   int answers_seen;
   int cmd_count [4];
   int no_free_count;
   int full_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void queue_answer(input nfpm_pkg::status_type s, input int idx,
                                        input longint unsigned d, input logic l);
      answer_type a;
      a.status      = s;
      a.point_index = INDEX_W'(idx);
      a.dist_sq     = DIST_W'(d);
      a.last        = l;
      pending_answers.push_back(a);
   endfunction

   // Apply one accepted request item to the shadow table and queue what it answers.
   task automatic predict_table_op(input nfpm_pkg::cmd_type c,
                                   input logic signed [COORD_W-1:0] x,
                                   input logic signed [COORD_W-1:0] y);
      longint dx;
      longint dy;
      longint unsigned d;
      longint unsigned best_d;
      int best;
      bit found;
      int free_list[$];
      cmd_count[c]++;
      case (c)
         nfpm_pkg::CMD_CLEAR: begin
            shadow_count = 0;
            foreach (shadow_used[i]) shadow_used[i] = 1'b0;
         end
         nfpm_pkg::CMD_ADD: begin
            if (shadow_count >= TABLE_DEPTH) begin
               full_count++;
               queue_answer(nfpm_pkg::STS_FULL, 0, 0, 1'b1);
            end else begin
               shadow_x[shadow_count]    = x;
               shadow_y[shadow_count]    = y;
               shadow_used[shadow_count] = 1'b0;
               shadow_count++;
            end
         end
         nfpm_pkg::CMD_QUERY: begin
            found  = 1'b0;
            best   = 0;
            best_d = 0;
            for (int i = 0; i < shadow_count; i++) begin
               if (!shadow_used[i]) begin
                  dx = longint'(shadow_x[i]) - longint'(x);
                  dy = longint'(shadow_y[i]) - longint'(y);
                  d  = longint'(dx * dx + dy * dy);
                  // Strict compare keeps the lowest index on a tie.
                  if (!found || d < best_d) begin
                     found  = 1'b1;
                     best   = i;
                     best_d = d;
                  end
               end
            end
            if (!found) begin
               no_free_count++;
               queue_answer(nfpm_pkg::STS_NO_FREE, 0, 0, 1'b1);
            end else begin
               shadow_used[best] = 1'b1;
               queue_answer(nfpm_pkg::STS_MATCHED, best, best_d, 1'b1);
            end
         end
         nfpm_pkg::CMD_REPORT: begin
            for (int i = 0; i < shadow_count; i++) begin
               if (!shadow_used[i]) free_list.push_back(i);
            end
            if (free_list.size() == 0) begin
               queue_answer(nfpm_pkg::STS_NONE, 0, 0, 1'b1);
            end else begin
               foreach (free_list[k]) begin
                  queue_answer(nfpm_pkg::STS_UNUSED, free_list[k], 0,
                               k == free_list.size() - 1);
               end
            end
         end
      endcase
   endtask

   // Drive one request item, idling at random first, and wait until it is taken.
   task automatic send_item(input nfpm_pkg::cmd_type c, input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
      while (!calm && $urandom_range(99) < 10) begin
         req_bus.valid <= 1'b0;
         req_bus.cmd   <= CMD_W'($urandom());
         req_bus.pos_x <= COORD_W'($urandom());
         req_bus.pos_y <= COORD_W'($urandom());
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= c;
      req_bus.pos_x <= x;
      req_bus.pos_y <= y;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_table_op(c, x, y);
      items_sent++;
   endtask

   // Hold the request side off until every expected item has come back.
   task automatic wait_for_answers();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   // Coordinates: mostly full range, some clustered near zero, some extremes.
   function automatic logic signed [COORD_W-1:0] rand_coord();
      int pick;
      pick = $urandom_range(9);
      if (pick < 6) return COORD_W'($urandom());
      if (pick < 9) return COORD_W'($urandom_range(15) - 8);
      return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
   endfunction

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   task automatic check_answer();
      answer_type want;
      if (pending_answers.size() == 0) begin
         $error("unexpected response item: status %0d, point_index %0d",
                rsp_bus.status, rsp_bus.point_index);
         errors++;
      end else begin
         want = pending_answers.pop_front();
         compare_field("status", 64'(want.status), 64'(rsp_bus.status));
         compare_field("point_index", 64'(want.point_index), 64'(rsp_bus.point_index));
         compare_field("dist_sq", 64'(want.dist_sq), 64'(rsp_bus.dist_sq));
         compare_field("last", 64'(want.last), 64'(rsp_bus.last));
      end
   endtask

   // Response side: check each accepted item and stall at random.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
            check_answer();
            answers_seen++;
            quiet_cycles = 0;
         end else if (!reset && req_bus.valid && req_bus.ready === 1'b1) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         rsp_bus.ready <= calm || ($urandom_range(99) >= 10);
      end
   end

   // Watchdog on cycles in which no item moves on either channel.
   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("Timeout after %0d cycles without a handshake", quiet_cycles);
      $display("Test completed with failures");
      $finish;
   end

   // Report and query on an empty table.
   task automatic test_empty_table();
      send_item(nfpm_pkg::CMD_REPORT, 0, 0);
      send_item(nfpm_pkg::CMD_QUERY, 16'sh7fff, 16'sh8000);
      send_item(nfpm_pkg::CMD_CLEAR, 16'sh8000, 16'sh7fff);
      send_item(nfpm_pkg::CMD_REPORT, 0, 0);
   endtask

   // Corner coordinates, including the largest possible distance.
   task automatic test_coordinate_extremes();
      send_item(nfpm_pkg::CMD_CLEAR, 0, 0);
      send_item(nfpm_pkg::CMD_ADD, 16'sh8000, 16'sh8000);
      send_item(nfpm_pkg::CMD_QUERY, 16'sh7fff, 16'sh7fff);
      send_item(nfpm_pkg::CMD_ADD, 16'sh7fff, 16'sh7fff);
      send_item(nfpm_pkg::CMD_ADD, 0, 0);
      send_item(nfpm_pkg::CMD_ADD, 16'sh8000, 16'sh7fff);
      send_item(nfpm_pkg::CMD_QUERY, 16'sh7fff, 16'sh8000);
      send_item(nfpm_pkg::CMD_QUERY, -16'sd1, -16'sd1);
      send_item(nfpm_pkg::CMD_REPORT, 0, 0);
   endtask

   // Equal distances go to the lowest index; clear also frees used points.
   task automatic test_tie_break();
      send_item(nfpm_pkg::CMD_CLEAR, 0, 0);
      send_item(nfpm_pkg::CMD_ADD, 16'sd3, 16'sd4);
      send_item(nfpm_pkg::CMD_ADD, -16'sd3, -16'sd4);
      send_item(nfpm_pkg::CMD_ADD, 16'sd4, -16'sd3);
      send_item(nfpm_pkg::CMD_QUERY, 0, 0);
      send_item(nfpm_pkg::CMD_QUERY, 0, 0);
      send_item(nfpm_pkg::CMD_REPORT, 0, 0);
      send_item(nfpm_pkg::CMD_QUERY, 0, 0);
      send_item(nfpm_pkg::CMD_QUERY, 0, 0);
      send_item(nfpm_pkg::CMD_REPORT, 0, 0);
      send_item(nfpm_pkg::CMD_CLEAR, 0, 0);
      send_item(nfpm_pkg::CMD_ADD, 16'sd1, 16'sd1);
      send_item(nfpm_pkg::CMD_REPORT, 0, 0);
   endtask

   // Fill the table, overflow it, then use up every point.
   task automatic test_full_table();
      send_item(nfpm_pkg::CMD_CLEAR, 0, 0);
      repeat (TABLE_DEPTH) send_item(nfpm_pkg::CMD_ADD, rand_coord(), rand_coord());
      send_item(nfpm_pkg::CMD_ADD, rand_coord(), rand_coord());
      send_item(nfpm_pkg::CMD_REPORT, 0, 0);
      wait_for_answers();
      repeat (TABLE_DEPTH + 1) send_item(nfpm_pkg::CMD_QUERY, rand_coord(), rand_coord());
      send_item(nfpm_pkg::CMD_REPORT, 0, 0);
      send_item(nfpm_pkg::CMD_ADD, rand_coord(), rand_coord());
   endtask

   // Sessions of clear (most of the time), a burst of adds, then mixed items, mostly queries and reports.
   task automatic test_random_sessions();
      int first_item;
      int session;
      int n_points;
      int pick;
      first_item = items_sent;
      session    = 0;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         calm = (session >= 6 && session < 10);
         if ($urandom_range(9) != 0) begin
            send_item(nfpm_pkg::CMD_CLEAR, rand_coord(), rand_coord());
         end
         pick = $urandom_range(99);
         if (pick < 80) n_points = $urandom_range(1, 12);
         else if (pick < 96) n_points = $urandom_range(13, 40);
         else n_points = $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 2);
         repeat (n_points) send_item(nfpm_pkg::CMD_ADD, rand_coord(), rand_coord());
         repeat ($urandom_range(4, 16)) begin
            pick = $urandom_range(99);
            if (pick < 60) send_item(nfpm_pkg::CMD_QUERY, rand_coord(), rand_coord());
            else if (pick < 80) send_item(nfpm_pkg::CMD_REPORT, rand_coord(), rand_coord());
            else if (pick < 95) send_item(nfpm_pkg::CMD_ADD, rand_coord(), rand_coord());
            else send_item(nfpm_pkg::CMD_CLEAR, rand_coord(), rand_coord());
         end
         if ($urandom_range(4) == 0) wait_for_answers();
         session++;
      end
      calm = 1'b0;
   endtask

   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd   <= nfpm_pkg::CMD_CLEAR;
      req_bus.pos_x <= '0;
      req_bus.pos_y <= '0;
      calm          = 1'b0;
      shadow_count  = 0;
      foreach (shadow_used[i]) shadow_used[i] = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_coordinate_extremes();
      test_tie_break();
      test_full_table();
      test_random_sessions();

      wait_for_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d request items: %0d clear, %0d add, %0d query, %0d report.",
               items_sent, cmd_count[nfpm_pkg::CMD_CLEAR], cmd_count[nfpm_pkg::CMD_ADD],
               cmd_count[nfpm_pkg::CMD_QUERY], cmd_count[nfpm_pkg::CMD_REPORT]);
      $display("Checked %0d response items, %0d with no free point and %0d with table full.",
               answers_seen, no_free_count, full_count);
      if (errors == 0 && pending_answers.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### nearest_free_point_matcher.f
src/nfpm_pkg.sv
src/nfpm_if.sv
src/nfpm_ram.sv
src/nearest_free_point_matcher.sv
tb/nearest_free_point_matcher_test.sv
